@@ hdl/tga_rle_pixel_encoder_core_assert.svh @@
// Assertion macros for the TGA RLE encoder core.
`ifndef TGA_RLE_PIXEL_ENCODER_CORE_ASSERT_SVH
`define TGA_RLE_PIXEL_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define TRE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define TRE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/tre_pkg.sv @@
// Shared types, constants and helpers of the TGA RLE encoder.
`default_nettype none

package tre_pkg;

    localparam int PIX_W          = 32;
    localparam int LANES          = 4;
    localparam int LANE_W         = 2;
    localparam int BPP_W          = 3;
    localparam int HDR_W          = 8;
    localparam int PCNT_W         = 3;
    localparam int DEF_MAX_PACKET = 128;
    localparam int APB_DW         = 32;
    localparam int ADDR_W         = 3;

    localparam logic [HDR_W-1:0]  RUN_BIAS  = 8'd127;
    localparam logic [BPP_W-1:0]  BPP_RESET = 3'd4;

    // register index field of paddr
    localparam logic [ADDR_W-3:0] REG_BPP_IDX = '0;

    // packet modes
    localparam logic [1:0] MODE_UNDEC = 2'd0;
    localparam logic [1:0] MODE_RAW   = 2'd1;
    localparam logic [1:0] MODE_RUN   = 2'd2;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [LANE_W-1:0] wr_lane;
    } t_store_ctl;

    // byte mask for the compared and emitted bytes; 0 acts as 1, above 4 as 4
    function automatic logic [PIX_W-1:0] f_mask(input logic [BPP_W-1:0] bpp);
        logic [PIX_W-1:0] m;
        unique case (bpp)
            3'd0, 3'd1: m = 32'h0000_00FF;
            3'd2:       m = 32'h0000_FFFF;
            3'd3:       m = 32'h00FF_FFFF;
            default:    m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

@@ hdl/tre_if.sv @@
// Stream interfaces: pixel input channel and packet result channel.
`default_nettype none

interface tre_pix_if import tre_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             final_pixel;

    modport source (output valid, pixel, final_pixel, input ready);
    modport sink   (input valid, pixel, final_pixel, output ready);
endinterface

interface tre_pkt_if import tre_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              header_valid;
    logic [HDR_W-1:0]  header_byte;
    logic [PCNT_W-1:0] pixel_count;
    logic [PIX_W-1:0]  pixel_a;
    logic [PIX_W-1:0]  pixel_b;
    logic [PIX_W-1:0]  pixel_c;
    logic [PIX_W-1:0]  pixel_d;
    logic              final_of_step;
    logic              image_done;

    modport source (output valid, header_valid, header_byte, pixel_count,
                    pixel_a, pixel_b, pixel_c, pixel_d, final_of_step, image_done,
                    input ready);
    modport sink   (input valid, header_valid, header_byte, pixel_count,
                    pixel_a, pixel_b, pixel_c, pixel_d, final_of_step, image_done,
                    output ready);
endinterface

`default_nettype wire

@@ hdl/tre_raw_store.sv @@
// Raw pixel store: four lane banks, one write and one row read per cycle.
`default_nettype none

module tre_raw_store import tre_pkg::*; #(
    parameter int  MAX_PACKET = DEF_MAX_PACKET,
    localparam int ROWS       = (MAX_PACKET + LANES - 1) / LANES,
    localparam int RW         = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  wire              i_clk,
    input  t_store_ctl       i_ctl,
    input  wire [RW-1:0]     i_wr_row,
    input  wire [PIX_W-1:0]  i_wr_data,
    input  wire [RW-1:0]     i_rd_row,
    output logic [PIX_W-1:0] o_rd_data [LANES]
);

    logic [PIX_W-1:0] mem [LANES][ROWS];
    logic [PIX_W-1:0] r_rd_data [LANES];

    // entry i sits in lane i%4, row i/4
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            mem[i_ctl.wr_lane][i_wr_row] <= i_wr_data;
        end
        if (i_ctl.re) begin
            for (int k = 0; k < LANES; k++) begin
                r_rd_data[k] <= mem[k][i_rd_row];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ hdl/tre_apb_regs.sv @@
// APB register file: bytes_per_pixel.
`default_nettype none

module tre_apb_regs import tre_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire [ADDR_W-1:0]  paddr,
    input  wire [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [BPP_W-1:0]  o_bpp
);

    logic [BPP_W-1:0] r_bpp;
    logic             hit;

    assign hit    = (paddr[ADDR_W-1:2] == REG_BPP_IDX);
    assign pready = 1'b1;
    assign prdata = hit ? APB_DW'(r_bpp) : '0;
    assign o_bpp  = r_bpp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp <= BPP_RESET;
        end else if (psel && penable && pwrite && hit) begin
            r_bpp <= pwdata[BPP_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ hdl/tre_encoder.sv @@
// Packet decision logic, emit sequencer and output register.
`default_nettype none

module tre_encoder import tre_pkg::*; #(
    parameter int  MAX_PACKET = DEF_MAX_PACKET,
    localparam int CW         = $clog2(MAX_PACKET + 1),
    localparam int ROWS       = (MAX_PACKET + LANES - 1) / LANES,
    localparam int RW         = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire [BPP_W-1:0]  i_bpp,
    tre_pix_if.sink          i_pix,
    tre_pkt_if.source        o_pkt,
    output t_store_ctl       o_st_ctl,
    output logic [RW-1:0]    o_wr_row,
    output logic [PIX_W-1:0] o_wr_data,
    output logic [RW-1:0]    o_rd_row,
    input  wire [PIX_W-1:0]  i_rd_data [LANES]
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_RAW  = 2'd2;
    localparam logic [1:0] S_RUN  = 2'd3;

    // packet state
    logic [PIX_W-1:0]  r_prev;
    logic [CW-1:0]     r_count;
    logic [1:0]        r_mode;

    // sequencer
    logic [1:0]        r_state;
    logic [CW-1:0]     r_job_cnt;
    logic [PIX_W-1:0]  r_job_pix;
    logic              r_job2_vld;
    logic              r_job2_run;
    logic [CW-1:0]     r_job2_cnt;
    logic [PIX_W-1:0]  r_job2_pix;
    logic              r_final;
    logic [CW-1:0]     r_left;
    logic [RW-1:0]     r_row;
    logic              r_first;

    // output register
    logic              r_o_vld;
    logic              r_o_hv;
    logic [HDR_W-1:0]  r_o_hb;
    logic [PCNT_W-1:0] r_o_pc;
    logic [PIX_W-1:0]  r_o_px [LANES];
    logic              r_o_fs;
    logic              r_o_id;

    // step decode
    logic              accept;
    logic [PIX_W-1:0]  mask;
    logic [PIX_W-1:0]  pix_m;
    logic [PIX_W-1:0]  prev_m;
    logic              same;
    logic [CW-1:0]     cnt_inc;
    logic              j1_vld;
    logic              j1_run;
    logic [CW-1:0]     j1_cnt;
    logic [PIX_W-1:0]  j1_pix;
    logic              st_we;
    logic [CW-1:0]     widx;
    logic [CW-1:0]     n_count;
    logic [1:0]        n_mode;
    logic              flush;

    // emit
    logic              slot_free;
    logic [7:0]        left8;
    logic              last_chunk;
    logic [PCNT_W-1:0] chunk;
    logic              rd_re;
    logic [RW-1:0]     rd_row;
    logic              load;
    logic              job_done;
    logic              res_hv;
    logic [HDR_W-1:0]  res_hb;
    logic [PCNT_W-1:0] res_pc;
    logic [PIX_W-1:0]  res_px [LANES];
    logic              res_fs;
    logic              res_id;

    assign i_pix.ready = (r_state == S_IDLE);
    assign accept      = i_pix.valid && i_pix.ready;

    always_comb begin
        mask    = f_mask(i_bpp);
        pix_m   = i_pix.pixel & mask;
        prev_m  = r_prev & mask;
        same    = (pix_m == prev_m);
        cnt_inc = r_count + CW'(1);
        j1_vld  = 1'b0;
        j1_run  = 1'b0;
        j1_cnt  = r_count;
        j1_pix  = r_prev;
        st_we   = 1'b0;
        widx    = '0;
        n_count = r_count;
        n_mode  = r_mode;
        priority if (r_count == '0) begin
            st_we   = 1'b1;
            n_count = CW'(1);
            n_mode  = MODE_UNDEC;
        end else if (r_mode == MODE_RUN) begin
            if (same) begin
                n_count = cnt_inc;
            end else begin
                // close the run with the pixel it was built on
                j1_vld  = 1'b1;
                j1_run  = 1'b1;
                st_we   = 1'b1;
                n_count = CW'(1);
                n_mode  = MODE_UNDEC;
            end
        end else if (r_mode == MODE_RAW) begin
            if (same) begin
                // last raw pixel moves into the new run
                j1_vld  = 1'b1;
                j1_cnt  = r_count - CW'(1);
                n_count = CW'(2);
                n_mode  = MODE_RUN;
            end else begin
                st_we   = 1'b1;
                widx    = r_count;
                n_count = cnt_inc;
            end
        end else begin
            n_count = CW'(2);
            if (same) begin
                n_mode = MODE_RUN;
            end else begin
                st_we  = 1'b1;
                widx   = CW'(1);
                n_mode = MODE_RAW;
            end
        end
        flush = (n_count == CW'(MAX_PACKET)) || i_pix.final_pixel;
    end

    assign o_st_ctl.we      = accept && st_we;
    assign o_st_ctl.re      = rd_re;
    assign o_st_ctl.wr_lane = widx[LANE_W-1:0];
    assign o_wr_row         = RW'(widx >> LANE_W);
    assign o_wr_data        = pix_m;
    assign o_rd_row         = rd_row;

    always_comb begin
        slot_free  = !r_o_vld || o_pkt.ready;
        left8      = 8'(r_left);
        last_chunk = (left8 <= 8'(LANES));
        chunk      = last_chunk ? PCNT_W'(left8) : PCNT_W'(LANES);
        rd_re      = 1'b0;
        rd_row     = r_row;
        load       = 1'b0;
        job_done   = 1'b0;
        res_hv     = 1'b0;
        res_hb     = '0;
        res_pc     = '0;
        for (int k = 0; k < LANES; k++) begin
            res_px[k] = '0;
        end
        unique case (r_state)
            S_IDLE: begin
            end
            S_RD: begin
                rd_re  = 1'b1;
                rd_row = '0;
            end
            S_RAW: begin
                if (slot_free) begin
                    load   = 1'b1;
                    res_hv = r_first;
                    res_hb = r_first ? (8'(r_job_cnt) - 8'd1) : '0;
                    res_pc = chunk;
                    for (int k = 0; k < LANES; k++) begin
                        res_px[k] = (PCNT_W'(k) < chunk) ? i_rd_data[k] : '0;
                    end
                    if (last_chunk) begin
                        job_done = 1'b1;
                    end else begin
                        // prefetch the next row while this one goes out
                        rd_re  = 1'b1;
                        rd_row = r_row + RW'(1);
                    end
                end
            end
            S_RUN: begin
                if (slot_free) begin
                    load      = 1'b1;
                    res_hv    = 1'b1;
                    res_hb    = 8'(r_job_cnt) + RUN_BIAS;
                    res_pc    = PCNT_W'(1);
                    res_px[0] = r_job_pix;
                    job_done  = 1'b1;
                end
            end
        endcase
        res_fs = job_done && !r_job2_vld;
        res_id = res_fs && r_final;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_o_vld    <= 1'b0;
            r_prev     <= '0;
            r_count    <= '0;
            r_mode     <= MODE_UNDEC;
            r_job2_vld <= 1'b0;
        end else begin
            if (load) begin
                r_o_vld <= 1'b1;
            end else if (o_pkt.ready) begin
                r_o_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_prev  <= pix_m;
                        r_count <= flush ? '0 : n_count;
                        r_mode  <= flush ? MODE_UNDEC : n_mode;
                        r_final <= i_pix.final_pixel;
                        if (j1_vld) begin
                            r_job_cnt  <= j1_cnt;
                            r_job_pix  <= j1_pix;
                            r_job2_vld <= flush;
                            r_job2_run <= (n_mode == MODE_RUN);
                            r_job2_cnt <= n_count;
                            r_job2_pix <= pix_m;
                            r_state    <= j1_run ? S_RUN : S_RD;
                        end else if (flush) begin
                            r_job_cnt  <= n_count;
                            r_job_pix  <= pix_m;
                            r_job2_vld <= 1'b0;
                            r_state    <= (n_mode == MODE_RUN) ? S_RUN : S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_left  <= r_job_cnt;
                    r_row   <= '0;
                    r_first <= 1'b1;
                    r_state <= S_RAW;
                end
                S_RAW: begin
                    if (load && !job_done) begin
                        r_left  <= r_left - CW'(LANES);
                        r_row   <= r_row + RW'(1);
                        r_first <= 1'b0;
                    end
                end
                S_RUN: begin
                end
            endcase
            if (job_done) begin
                if (r_job2_vld) begin
                    r_job_cnt  <= r_job2_cnt;
                    r_job_pix  <= r_job2_pix;
                    r_job2_vld <= 1'b0;
                    r_state    <= r_job2_run ? S_RUN : S_RD;
                end else begin
                    r_state <= S_IDLE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_hv <= res_hv;
            r_o_hb <= res_hb;
            r_o_pc <= res_pc;
            r_o_px <= res_px;
            r_o_fs <= res_fs;
            r_o_id <= res_id;
        end
    end

    assign o_pkt.valid         = r_o_vld;
    assign o_pkt.header_valid  = r_o_hv;
    assign o_pkt.header_byte   = r_o_hb;
    assign o_pkt.pixel_count   = r_o_pc;
    assign o_pkt.pixel_a       = r_o_px[0];
    assign o_pkt.pixel_b       = r_o_px[1];
    assign o_pkt.pixel_c       = r_o_px[2];
    assign o_pkt.pixel_d       = r_o_px[3];
    assign o_pkt.final_of_step = r_o_fs;
    assign o_pkt.image_done    = r_o_id;

endmodule

`default_nettype wire

@@ hdl/tga_rle_pixel_encoder_core.sv @@
// Top level of the TGA RLE pixel encoder core.
//
//  channel  | kind         | dir | carries
//  ---------+--------------+-----+---------------------------------------------
//  i_pix    | valid/ready  | in  | pixel, final_pixel
//  o_pkt    | valid/ready  | out | header, up to four pixels, step/image flags
//  APB      | psel/penable | in  | bytes_per_pixel at byte address 0
//
// A pixel that closes no packet leaves ready high, so such pixels can follow
// back to back.
// A run packet goes out as one result; a raw packet of n pixels takes one
// store read and then ceil(n/4) results, each from one row of the four-lane
// raw store. i_pix.ready is low while packets are emitted; a result
// waiting in the output register does not hold off the next pixel.
// Output stalls freeze the sequencer. Reset is synchronous; the raw store is
// not cleared, since each entry is written before it is read within a packet.
`default_nettype none

module tga_rle_pixel_encoder_core import tre_pkg::*; #(
    parameter int  MAX_PACKET = DEF_MAX_PACKET,
    localparam int ROWS       = (MAX_PACKET + LANES - 1) / LANES,
    localparam int RW         = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    tre_pix_if.sink           i_pix,
    tre_pkt_if.source         o_pkt,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire [ADDR_W-1:0]  paddr,
    input  wire [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    `include "tga_rle_pixel_encoder_core_assert.svh"

    logic [BPP_W-1:0] bpp;
    t_store_ctl       st_ctl;
    logic [RW-1:0]    wr_row;
    logic [PIX_W-1:0] wr_data;
    logic [RW-1:0]    rd_row;
    logic [PIX_W-1:0] rd_data [LANES];
    logic             pix_fin_acc;
    logic             run_out;
    logic             pcnt_ok;

    tre_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_bpp   (bpp)
    );

    tre_raw_store #(.MAX_PACKET(MAX_PACKET)) u_store (
        .i_clk     (i_clk),
        .i_ctl     (st_ctl),
        .i_wr_row  (wr_row),
        .i_wr_data (wr_data),
        .i_rd_row  (rd_row),
        .o_rd_data (rd_data)
    );

    tre_encoder #(.MAX_PACKET(MAX_PACKET)) u_enc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_bpp     (bpp),
        .i_pix     (i_pix),
        .o_pkt     (o_pkt),
        .o_st_ctl  (st_ctl),
        .o_wr_row  (wr_row),
        .o_wr_data (wr_data),
        .o_rd_row  (rd_row),
        .i_rd_data (rd_data)
    );

    assign pix_fin_acc = i_pix.valid && i_pix.ready && i_pix.final_pixel;
    assign run_out     = o_pkt.valid && o_pkt.header_valid && o_pkt.header_byte[7];
    assign pcnt_ok     = (o_pkt.pixel_count != 3'd0) && (o_pkt.pixel_count <= 3'd4);

    // a final pixel always flushes something, so the sequencer must go busy
    `TRE_ASSERT_NEXT(a_final_busy, pix_fin_acc, !i_pix.ready, "final pixel produced no packet")
    // run packets carry exactly one pixel
    `TRE_ASSERT_NOW(a_run_one_px, run_out, o_pkt.pixel_count == 3'd1, "run packet pixel count")
    `TRE_ASSERT_NOW(a_pcnt_range, o_pkt.valid, pcnt_ok, "pixel count out of range")
    `TRE_ASSERT_NOW(a_done_last, o_pkt.valid && o_pkt.image_done, o_pkt.final_of_step, "image done early")

endmodule

`default_nettype wire
